>>> rtl/eiplp_pkg.sv
// ----------------------------------------------------------------------------
// eiplp_pkg
// Shared types and constants for the Ethernet/IP/L4 header parser.
// ----------------------------------------------------------------------------
package eiplp_pkg;

   localparam logic [15:0] ETH_VLAN = 16'h8100;
   localparam logic [15:0] ETH_QINQ = 16'h88a8;
   localparam logic [15:0] ETH_LLDP = 16'h88cc;
   localparam logic [15:0] ETH_CDP  = 16'h2000;
   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86dd;
   localparam logic [4:0]  BASE_OFFSET = 5'd14;
   localparam logic [7:0]  IPV6_HDR = 8'd40;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   localparam logic [2:0] VERDICT_FLOW  = 3'd0;
   localparam logic [2:0] VERDICT_NONIP = 3'd1;
   localparam logic [2:0] VERDICT_LLDP  = 3'd2;
   localparam logic [2:0] VERDICT_OTHER = 3'd3;
   localparam logic [2:0] VERDICT_TRUNC = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // one parsed frame summary, handed from front to back
   typedef struct packed {
      logic [2:0]  verdict;
      logic        is_ipv6;
      logic [7:0]  protocol;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [11:0] vlan_id;
      logic [2:0]  priority_res;
      logic [15:0] ether_type;
      logic [7:0]  tcp_flag_bits;
      logic [15:0] payload_length;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
   } summary_type;

endpackage

>>> rtl/ethernet_ip_l4_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser
// Ethernet/VLAN/IPv4/IPv6/TCP/UDP five-tuple parser, one frame byte a request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req_      in         push / full      data_byte, frame_length, end_of_frame
//  rsp_      out        empty / pop      summary fields, address_word, last_word
//
//  One byte per cycle while full is low; the end-of-frame byte yields four
//  result words, popped one per cycle from a four-frame summary queue.
//  If the queue was empty, the first word shows the cycle after end of frame.
//  full is raised only while that queue holds four undrained frames.
//  Reset is synchronous and clears the byte counter and the queue.
module ethernet_ip_l4_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_frame_length,
   input  logic        req_end_of_frame,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_is_ipv6,
   output logic [7:0]  rsp_protocol,
   output logic [15:0] rsp_sport,
   output logic [15:0] rsp_dport,
   output logic [11:0] rsp_vlan_id,
   output logic [2:0]  rsp_priority_res,
   output logic [15:0] rsp_ether_type,
   output logic [7:0]  rsp_tcp_flag_bits,
   output logic [15:0] rsp_payload_length,
   output logic [63:0] rsp_address_word,
   output logic        rsp_last_word
);

   logic accept, sum_valid;
   eiplp_pkg::summary_type sum_data, head;
   logic [1:0] word_sel;

   assign accept = push && !full;

   eiplp_front u_front (
      .clock(clock), .reset(reset), .byte_valid(accept),
      .data_byte(req_data_byte), .frame_length(req_frame_length),
      .end_of_frame(req_end_of_frame), .sum_valid(sum_valid), .sum_data(sum_data)
   );

   eiplp_back u_back (
      .clock(clock), .reset(reset), .sum_valid(sum_valid), .sum_data(sum_data),
      .q_full(full), .rsp_empty(empty), .rsp_pop(pop), .head(head),
      .word_sel(word_sel)
   );

   always_comb begin
      rsp_verdict = head.verdict;
      rsp_is_ipv6 = head.is_ipv6;
      rsp_protocol = head.protocol;
      rsp_sport = head.sport;
      rsp_dport = head.dport;
      rsp_vlan_id = head.vlan_id;
      rsp_priority_res = head.priority_res;
      rsp_ether_type = head.ether_type;
      rsp_tcp_flag_bits = head.tcp_flag_bits;
      rsp_payload_length = head.payload_length;
      rsp_last_word = word_sel == 2'd3;
      case (word_sel)
         2'd0: rsp_address_word = head.src_hi;
         2'd1: rsp_address_word = head.src_lo;
         2'd2: rsp_address_word = head.dst_hi;
         2'd3: rsp_address_word = head.dst_lo;
         default: rsp_address_word = '0;
      endcase
   end

   a_trunc_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_verdict == eiplp_pkg::VERDICT_TRUNC) |-> rsp_address_word == '0)
      else $error("truncated frame carries an address");
   a_udp_flags: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_protocol == eiplp_pkg::PROTO_UDP) |-> rsp_tcp_flag_bits == '0)
      else $error("udp frame carries tcp flags");
   a_word_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_last_word))
      else $error("result word moved while stalled");

endmodule

>>> rtl/eiplp_front.sv
// ----------------------------------------------------------------------------
// eiplp_front
// Byte counter and field capture; builds a frame summary on end of frame.
// ----------------------------------------------------------------------------
module eiplp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             data_byte,
   input  logic [15:0]            frame_length,
   input  logic                   end_of_frame,
   output logic                   sum_valid,
   output eiplp_pkg::summary_type sum_data
);

   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] type_ff, type_in;
   logic [4:0]  net_off_ff, net_off_in;
   logic [7:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic        v6_ff, v6_in;
   logic [63:0] src_ff [2];
   logic [63:0] src_in [2];
   logic [63:0] dst_ff [2];
   logic [63:0] dst_in [2];
   logic [15:0] port_ff [2];
   logic [15:0] port_in [2];
   logic [14:0] tag_ff, tag_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  l4len_ff, l4len_in;

   logic        is4, is6;
   logic [16:0] r3, l4s, r4, count;
   logic [16:0] l3pay, pay;
   logic [16:0] need3, need4, minpay;
   eiplp_pkg::summary_type s;
   logic [15:0] i;
   logic [7:0]  b;

   always_comb begin
      i = byte_index_ff;
      b = data_byte;
      byte_index_in = byte_index_ff;
      type_in = type_ff;
      net_off_in = net_off_ff;
      ihl_in = ihl_ff;
      proto_in = proto_ff;
      v6_in = v6_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      port_in = port_ff;
      tag_in = tag_ff;
      flags_in = flags_ff;
      l4len_in = l4len_ff;

      if (i == 16'd12) type_in = {b, 8'h00};
      if (i == 16'd13) begin
         type_in = {type_ff[15:8], b};
         if ({type_ff[15:8], b} == eiplp_pkg::ETH_VLAN) net_off_in = 5'd18;
         else if ({type_ff[15:8], b} == eiplp_pkg::ETH_QINQ) net_off_in = 5'd22;
      end
      if (net_off_ff == 5'd18) begin
         if (i == 16'd14) tag_in = {b[7:5], b[3:0], 8'h00};
         if (i == 16'd15) tag_in = {tag_ff[14:8], b};
         if (i == 16'd16) type_in = {b, 8'h00};
         if (i == 16'd17) type_in = {type_ff[15:8], b};
      end else if (net_off_ff == 5'd22) begin
         if (i == 16'd20) type_in = {b, 8'h00};
         if (i == 16'd21) type_in = {type_ff[15:8], b};
      end

      // classification sees the ethertype after this byte's update
      is4 = type_in == eiplp_pkg::ETH_IPV4;
      is6 = type_in == eiplp_pkg::ETH_IPV6;

      r3 = {1'b0, i} - {12'd0, net_off_ff};
      if ({1'b0, i} >= {12'd0, net_off_ff}) begin
         if (r3 == 17'd0) v6_in = is6;
         if (is4) begin
            if (r3 == 17'd0) ihl_in = {2'b00, b[3:0], 2'b00};
            if (r3 == 17'd9) proto_in = b;
            if (r3 >= 17'd12 && r3 < 17'd16) src_in[1] = {src_ff[1][55:0], b};
            if (r3 >= 17'd16 && r3 < 17'd20) dst_in[1] = {dst_ff[1][55:0], b};
         end else if (is6) begin
            if (r3 == 17'd6) proto_in = b;
            if (r3 >= 17'd8 && r3 < 17'd16) src_in[0] = {src_ff[0][55:0], b};
            if (r3 >= 17'd16 && r3 < 17'd24) src_in[1] = {src_ff[1][55:0], b};
            if (r3 >= 17'd24 && r3 < 17'd32) dst_in[0] = {dst_ff[0][55:0], b};
            if (r3 >= 17'd32 && r3 < 17'd40) dst_in[1] = {dst_ff[1][55:0], b};
         end
      end

      // L4 start uses the header length as updated by this byte
      l4s = {12'd0, net_off_ff} + {9'd0, (is6 ? eiplp_pkg::IPV6_HDR : ihl_in)};
      r4 = {1'b0, i} - l4s;
      if ((is4 || is6) && {1'b0, i} >= l4s) begin
         if (r4 < 17'd2) port_in[0] = {port_ff[0][7:0], b};
         else if (r4 < 17'd4) port_in[1] = {port_ff[1][7:0], b};
         if (r4 == 17'd12) l4len_in = {2'b00, b[7:4], 2'b00};
         if (r4 == 17'd13) flags_in = b;
      end

      if (byte_index_ff != 16'hffff) byte_index_in = byte_index_ff + 16'd1;

      // summary from the updated state
      count = {1'b0, i} + 17'd1;
      l3pay = ({1'b0, frame_length} > l4s) ? {1'b0, frame_length} - l4s : 17'd0;
      need3 = {12'd0, net_off_ff} + (is6 ? 17'd40 : 17'd20);
      need4 = l4s + ((proto_in == eiplp_pkg::PROTO_TCP) ? 17'd14 : 17'd4);
      minpay = (proto_in == eiplp_pkg::PROTO_TCP) ? 17'd20 : 17'd8;
      pay = (proto_in == eiplp_pkg::PROTO_TCP) ? {9'd0, l4len_in} : 17'd8;
      s = '0;
      if (count < {12'd0, net_off_in}) begin
         s.verdict = eiplp_pkg::VERDICT_TRUNC;
      end else begin
         s.ether_type = type_in;
         if (net_off_in == 5'd18) begin
            s.vlan_id = tag_in[11:0];
            s.priority_res = tag_in[14:12];
         end
         if (type_in == eiplp_pkg::ETH_LLDP || type_in == eiplp_pkg::ETH_CDP)
            s.verdict = eiplp_pkg::VERDICT_LLDP;
         else if (!is4 && !is6)
            s.verdict = eiplp_pkg::VERDICT_NONIP;
         else if (count < need3) begin
            s = '0;
            s.verdict = eiplp_pkg::VERDICT_TRUNC;
         end else begin
            s.is_ipv6 = v6_in;
            s.protocol = proto_in;
            s.src_hi = src_in[0];
            s.src_lo = src_in[1];
            s.dst_hi = dst_in[0];
            s.dst_lo = dst_in[1];
            if (proto_in == eiplp_pkg::PROTO_TCP || proto_in == eiplp_pkg::PROTO_UDP) begin
               if (l3pay < minpay) s.verdict = eiplp_pkg::VERDICT_OTHER;
               else if (count < need4) begin
                  s = '0;
                  s.verdict = eiplp_pkg::VERDICT_TRUNC;
               end else begin
                  s.verdict = eiplp_pkg::VERDICT_FLOW;
                  s.sport = port_in[0];
                  s.dport = port_in[1];
                  if (proto_in == eiplp_pkg::PROTO_TCP) s.tcp_flag_bits = flags_in;
                  s.payload_length = (l3pay > pay) ? 16'(l3pay - pay) : 16'd0;
               end
            end else begin
               s.verdict = eiplp_pkg::VERDICT_OTHER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && end_of_frame)) begin
         byte_index_ff <= '0;
         type_ff <= '0;
         net_off_ff <= eiplp_pkg::BASE_OFFSET;
         ihl_ff <= '0;
         proto_ff <= '0;
         v6_ff <= 1'b0;
         src_ff <= '{default: '0};
         dst_ff <= '{default: '0};
         port_ff <= '{default: '0};
         tag_ff <= '0;
         flags_ff <= '0;
         l4len_ff <= '0;
      end else if (byte_valid) begin
         byte_index_ff <= byte_index_in;
         type_ff <= type_in;
         net_off_ff <= net_off_in;
         ihl_ff <= ihl_in;
         proto_ff <= proto_in;
         v6_ff <= v6_in;
         src_ff <= src_in;
         dst_ff <= dst_in;
         port_ff <= port_in;
         tag_ff <= tag_in;
         flags_ff <= flags_in;
         l4len_ff <= l4len_in;
      end
   end

   assign sum_valid = byte_valid && end_of_frame;
   assign sum_data = s;

endmodule

>>> rtl/eiplp_back.sv
// ----------------------------------------------------------------------------
// eiplp_back
// Summary queue and word sequencer: four result requests per frame.
// ----------------------------------------------------------------------------
module eiplp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sum_valid,
   input  eiplp_pkg::summary_type sum_data,
   output logic                   q_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output eiplp_pkg::summary_type head,
   output logic [1:0]             word_sel
);

   localparam int CW = eiplp_pkg::QPTR_W + 1;

   eiplp_pkg::summary_type mem_ff [eiplp_pkg::QUEUE_DEPTH];
   logic [eiplp_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0] word_ff, word_in;
   logic push, pop_frame;

   assign push = sum_valid;
   assign rsp_empty = cnt_ff == '0;
   assign q_full = cnt_ff == CW'(eiplp_pkg::QUEUE_DEPTH);
   assign pop_frame = rsp_pop && !rsp_empty && word_ff == 2'd3;
   assign head = mem_ff[rd_ff];
   assign word_sel = word_ff;

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop_frame ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop_frame);
      word_in = (rsp_pop && !rsp_empty) ? word_ff + 2'd1 : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         word_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= sum_data;
   end

endmodule
